@@ design/decay_time_histogram_defines.svh @@
// Assertion macros for the checker file.
`ifndef DECAY_TIME_HISTOGRAM_DEFINES_SVH
`define DECAY_TIME_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DTH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that is also checked around reset.
`define DTH_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/dth_pkg.sv @@
package dth_pkg;

  // Histogram store
  localparam int MAX_BINS       = 1024;
  localparam int COUNT_BITS     = 32;
  localparam int ADDR_BITS      = $clog2(MAX_BINS);
  localparam int EFF_BITS       = ADDR_BITS + 1;

  // Field widths
  localparam int OP_BITS        = 2;
  localparam int TIME_BITS      = 24;
  localparam int WIDTH_BITS     = 20;
  localparam int BINS_BITS      = 11;
  localparam int READ_BITS      = 10;
  localparam int INDEX_BITS     = 10;
  localparam int OUT_COUNT_BITS = 32;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  // Register reset values
  localparam logic [WIDTH_BITS-1:0] BIN_WIDTH_RESET   = WIDTH_BITS'(320);
  localparam logic [TIME_BITS-1:0]  TIME_CUTOFF_RESET = TIME_BITS'(639984);
  localparam logic [BINS_BITS-1:0]  BINS_IN_USE_RESET = BINS_BITS'(1000);

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS    = TIME_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BIN_WIDTH   = 2'd0,
    CFG_TIME_CUTOFF = 2'd1,
    CFG_BINS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Which result the datapath captures
  typedef enum logic [2:0] {
    RES_ZERO     = 3'd0,
    RES_MISS     = 3'd1,
    RES_HIT_READ = 3'd2,
    RES_HIT_REC  = 3'd3,
    RES_CLEAR    = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    logic     div_step;
    logic     sweep;
    logic     mem_wr;
    logic     rec_mode;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic sweep_last;
    logic hit;
  } status_t;

endpackage

@@ design/decay_time_histogram.sv @@
// Record: 24 divider steps, range check, counter read and write, output load; a
// dropped sample skips the counter read and write. Read: no divider, no write; out
// of range, no counter read either. Clear: 1024 counters, one zeroed per cycle;
// unused operation: output load only. A new item transfers after the output load,
// also while the last result waits. Reset (synchronous, active high) restores the
// registers and runs a pass that zeroes the store; no item transfers until it ends.
module decay_time_histogram (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [dth_pkg::OP_BITS-1:0]         operation,
  input  logic [dth_pkg::TIME_BITS-1:0]       sample_time,
  input  logic [dth_pkg::READ_BITS-1:0]       read_bin,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [dth_pkg::INDEX_BITS-1:0]      bin_index,
  output logic [dth_pkg::OUT_COUNT_BITS-1:0]  bin_count,
  output logic                                accepted,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dth_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [dth_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import dth_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  dth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .operation(operation),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  dth_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .sample_time(sample_time),
    .read_bin   (read_bin),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .bin_index  (bin_index),
    .bin_count  (bin_count),
    .accepted   (accepted)
  );

endmodule

@@ design/dth_ram.sv @@
module dth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/dth_ctrl.sv @@
module dth_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [dth_pkg::OP_BITS-1:0] operation,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output dth_pkg::cmd_t              cmd,
  input  dth_pkg::status_t           sts
);
  import dth_pkg::*;

  typedef enum logic [7:0] {
    S_INIT   = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_DIV    = 8'b00000100,
    S_RANGE  = 8'b00001000,
    S_READ   = 8'b00010000,
    S_UPDATE = 8'b00100000,
    S_CLEAR  = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state, state_next;
  op_t    op_q;
  logic   rec_mode;
  logic   slot_free;

  assign rec_mode  = (op_q == OP_RECORD);
  assign req_stall = (state != S_IDLE);
  // Output register can take a new result this cycle
  assign slot_free = !rsp_valid || !rsp_stall;

  // Next state and datapath commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_sel  = RES_ZERO;
    cmd.rec_mode = rec_mode;
    case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          case (op_t'(operation))
            OP_RECORD: state_next = S_DIV;
            OP_READ:   state_next = S_RANGE;
            OP_CLEAR:  state_next = S_CLEAR;
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_RANGE;
        end
      end
      S_RANGE: begin
        if (sts.hit) begin
          state_next = S_READ;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = rec_mode ? RES_ZERO : RES_MISS;
          state_next   = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.mem_wr   = rec_mode;
        cmd.res_load = 1'b1;
        cmd.res_sel  = rec_mode ? RES_HIT_REC : RES_HIT_READ;
        state_next   = S_DONE;
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_CLEAR;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, latched operation and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      op_q      <= OP_RECORD;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        op_q <= op_t'(operation);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/dth_datapath.sv @@
module dth_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dth_pkg::cmd_t                       cmd,
  output dth_pkg::status_t                    sts,
  input  logic [dth_pkg::TIME_BITS-1:0]       sample_time,
  input  logic [dth_pkg::READ_BITS-1:0]       read_bin,
  input  logic                                cfg_wr,
  input  logic [dth_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [dth_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic [dth_pkg::INDEX_BITS-1:0]      bin_index,
  output logic [dth_pkg::OUT_COUNT_BITS-1:0]  bin_count,
  output logic                                accepted
);
  import dth_pkg::*;

  // Configuration
  logic [WIDTH_BITS-1:0]   bin_span;
  logic [TIME_BITS-1:0]    time_cutoff;
  logic [BINS_BITS-1:0]    bins_in_use;
  logic [EFF_BITS-1:0]     bins_eff;

  // Item and divider
  logic [TIME_BITS-1:0]    time_q;
  logic [READ_BITS-1:0]    rb_q;
  logic [WIDTH_BITS-1:0]   rem;
  logic [WIDTH_BITS-1:0]   rem_next;
  logic [TIME_BITS-1:0]    quo;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [WIDTH_BITS:0]     trial;
  logic [WIDTH_BITS:0]     diff;
  logic                    trial_ge;
  logic                    sample_ok;

  // Store access
  logic [ADDR_BITS-1:0]    clr_addr;
  logic [ADDR_BITS-1:0]    bin_addr;
  logic [ADDR_BITS-1:0]    wr_addr;
  logic [COUNT_BITS-1:0]   wr_data;
  logic [COUNT_BITS-1:0]   rd_data;
  logic [COUNT_BITS-1:0]   count_inc;
  logic                    wr_en;

  // Captured result
  logic [INDEX_BITS-1:0]   res_idx;
  logic [COUNT_BITS-1:0]   res_cnt;
  logic                    res_ok;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_span    <= BIN_WIDTH_RESET;
      time_cutoff <= TIME_CUTOFF_RESET;
      bins_in_use <= BINS_IN_USE_RESET;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BIN_WIDTH:   bin_span    <= cfg_data[WIDTH_BITS-1:0];
        CFG_TIME_CUTOFF: time_cutoff <= cfg_data[TIME_BITS-1:0];
        CFG_BINS_IN_USE: bins_in_use <= cfg_data[BINS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign bins_eff = (32'(bins_in_use) > 32'(MAX_BINS)) ? EFF_BITS'(MAX_BINS)
                                                       : EFF_BITS'(bins_in_use);

  // One restoring step on (t - 1) / bin_span
  assign trial    = {rem, quo[TIME_BITS-1]};
  assign trial_ge = (trial >= {1'b0, bin_span});
  assign diff     = trial - {1'b0, bin_span};
  assign rem_next = trial_ge ? diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      time_q <= sample_time;
      rb_q   <= read_bin;
      rem    <= '0;
      quo    <= sample_time - TIME_BITS'(1);
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= {quo[TIME_BITS-2:0], trial_ge};
    end
  end

  // Step and sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt  <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.accept) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_BITS'(1);
      end
      if (cmd.sweep) begin
        clr_addr <= sts.sweep_last ? '0 : clr_addr + ADDR_BITS'(1);
      end
    end
  end

  // Status to the controller
  assign sample_ok      = (bin_span != '0) && (time_q != '0) && (time_q <= time_cutoff);
  assign sts.div_last   = (div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));
  assign sts.sweep_last = (clr_addr == ADDR_BITS'(MAX_BINS - 1));
  assign sts.hit        = cmd.rec_mode ? (sample_ok && (32'(quo) < 32'(bins_eff)))
                                       : (32'(rb_q) < 32'(bins_eff));

  // Store: sweep writes zero, update writes the saturated count
  assign bin_addr  = cmd.rec_mode ? quo[ADDR_BITS-1:0] : ADDR_BITS'(rb_q);
  assign count_inc = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);
  assign wr_en     = cmd.sweep || cmd.mem_wr;
  assign wr_addr   = cmd.sweep ? clr_addr : bin_addr;
  assign wr_data   = cmd.sweep ? '0 : count_inc;

  dth_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MAX_BINS)
  ) u_counts (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(bin_addr),
    .rd_data(rd_data)
  );

  // Result capture
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_MISS: begin
          res_idx <= INDEX_BITS'(rb_q);
          res_cnt <= '0;
          res_ok  <= 1'b0;
        end
        RES_HIT_READ: begin
          res_idx <= INDEX_BITS'(bin_addr);
          res_cnt <= rd_data;
          res_ok  <= 1'b1;
        end
        RES_HIT_REC: begin
          res_idx <= INDEX_BITS'(bin_addr);
          res_cnt <= count_inc;
          res_ok  <= 1'b1;
        end
        RES_CLEAR: begin
          res_idx <= '0;
          res_cnt <= '0;
          res_ok  <= 1'b1;
        end
        default: begin
          res_idx <= '0;
          res_cnt <= '0;
          res_ok  <= 1'b0;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_index <= res_idx;
      bin_count <= OUT_COUNT_BITS'(res_cnt);
      accepted  <= res_ok;
    end
  end

endmodule

@@ design/dth_checker.sv @@
`include "decay_time_histogram_defines.svh"

module dth_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_stall,
  input logic                                rsp_valid,
  input logic                                rsp_stall,
  input logic [dth_pkg::INDEX_BITS-1:0]      bin_index,
  input logic [dth_pkg::OUT_COUNT_BITS-1:0]  bin_count,
  input logic                                accepted
);

  // A stalled result stays valid and unchanged
  `DTH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(bin_index) && $stable(bin_count) && $stable(accepted), "result changed while stalled")

  // A dropped sample, missed read or unused operation reports a zero count
  `DTH_ASSERT_NOW(a_drop_zero, rsp_valid && !accepted, bin_count == '0, "rejected result with nonzero count")

  // One item at a time: after a transfer the input stalls
  `DTH_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "second item taken while busy")

  // The store clearing pass follows reset, so the input stalls
  `DTH_ASSERT_ALWAYS(a_init_stall, !rst && $past(rst), req_stall, "item taken during clearing pass")

endmodule

bind decay_time_histogram dth_checker u_dth_checker (.*);

@@ dv/tb_decay_time_histogram.sv @@
`timescale 1ns / 1ps
module tb_decay_time_histogram;
  import dth_pkg::*;

  // Op code 3 has no enum member; the block must answer it with all zeros
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [INDEX_BITS-1:0]     index;
    logic [OUT_COUNT_BITS-1:0] count;
    logic                      ok;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [OP_BITS-1:0] operation = '0;
  logic [TIME_BITS-1:0] sample_time = '0;
  logic [READ_BITS-1:0] read_bin = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [INDEX_BITS-1:0] bin_index;
  logic [OUT_COUNT_BITS-1:0] bin_count;
  logic accepted;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  decay_time_histogram dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .sample_time (sample_time),
    .read_bin    (read_bin),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .bin_index   (bin_index),
    .bin_count   (bin_count),
    .accepted    (accepted),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Histogram mirror: registers and counters as the block should hold them
  logic [COUNT_BITS-1:0] hist_counts [MAX_BINS];
  logic [WIDTH_BITS-1:0] width_q;
  logic [TIME_BITS-1:0]  cutoff_q;
  logic [BINS_BITS-1:0]  bins_q;

  bin_result_t expected_bin_results [$];
  int mismatches = 0;

  // Sender burst state
  int  burst_left = 0;
  bit  req_held = 1'b0;

  // Receiver stall pattern
  int stall_span = 0;
  int stall_style = 0;

  task automatic reset_histogram_model();
    width_q  = BIN_WIDTH_RESET;
    cutoff_q = TIME_CUTOFF_RESET;
    bins_q   = BINS_IN_USE_RESET;
    foreach (hist_counts[i]) hist_counts[i] = '0;
  endtask

  function automatic int unsigned bins_effective();
    return (bins_q > MAX_BINS) ? MAX_BINS : bins_q;
  endfunction

  // Apply one accepted item to the mirror and queue the result it must give
  function automatic void predict_bin_update(input logic [OP_BITS-1:0] op,
                                             input logic [TIME_BITS-1:0] t,
                                             input logic [READ_BITS-1:0] rb);
    bin_result_t r;
    logic [TIME_BITS-1:0] bin;
    int unsigned eff;
    r = '0;
    eff = bins_effective();
    case (op)
      OP_RECORD: begin
        if (width_q != 0 && t != 0 && t <= cutoff_q) begin
          bin = TIME_BITS'((t - 1) / width_q);
          if (bin < eff) begin
            if (hist_counts[bin] != '1) hist_counts[bin] = hist_counts[bin] + 1'b1;
            r.index = bin[INDEX_BITS-1:0];
            r.count = hist_counts[bin];
            r.ok    = 1'b1;
          end
        end
      end
      OP_READ: begin
        r.index = rb;
        if (rb < eff) begin
          r.count = hist_counts[rb];
          r.ok    = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (hist_counts[i]) hist_counts[i] = '0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    expected_bin_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // One request transfer; sender sends in bursts with random idle gaps
  task automatic send_bin_op(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] t,
                             input logic [READ_BITS-1:0] rb);
    int gap;
    req_valid   <= 1'b1;
    operation   <= op;
    sample_time <= t;
    read_bin    <= rb;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_bin_update(op, t, rb);
    if (burst_left > 0) begin
      burst_left--;
      req_held = 1'b1;
    end else begin
      req_valid <= 1'b0;
      req_held = 1'b0;
      gap = $urandom_range(8, 1);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 0);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every queued result has come back
  task automatic wait_histogram_idle();
    if (req_held) begin
      req_valid <= 1'b0;
      req_held = 1'b0;
    end
    while (expected_bin_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t reg_sel, input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (reg_sel)
      CFG_BIN_WIDTH:   width_q  = value[WIDTH_BITS-1:0];
      CFG_TIME_CUTOFF: cutoff_q = value[TIME_BITS-1:0];
      CFG_BINS_IN_USE: bins_q   = value[BINS_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Bin edges, cutoff, last bin, reads in and out of range, clear, unused op
  task automatic test_default_binning();
    send_bin_op(OP_RECORD, 24'd0, '0);
    send_bin_op(OP_RECORD, 24'd1, '0);
    send_bin_op(OP_RECORD, 24'd320, '0);
    send_bin_op(OP_RECORD, 24'd321, '0);
    send_bin_op(OP_RECORD, 24'd320000, '0);
    send_bin_op(OP_RECORD, 24'd320001, '0);
    send_bin_op(OP_RECORD, 24'd639985, '0);
    send_bin_op(OP_RECORD, 24'hFFFFFF, 10'h3FF);
    send_bin_op(OP_READ, 24'hFFFFFF, 10'd0);
    send_bin_op(OP_READ, '0, 10'd999);
    send_bin_op(OP_READ, '0, 10'd1000);
    send_bin_op(OP_READ, '0, 10'h3FF);
    send_bin_op(OP_UNUSED, TIME_BITS'($urandom_range(24'hFFFFFF, 0)),
                READ_BITS'($urandom_range(1023, 0)));
    send_bin_op(OP_CLEAR, '0, '0);
    send_bin_op(OP_READ, '0, 10'd0);
  endtask

  // Unit width, bins in use beyond the store, zero width, zero cutoff and zero bins
  task automatic test_register_extremes();
    wait_histogram_idle();
    write_reg(CFG_BIN_WIDTH, 24'd1);
    write_reg(CFG_TIME_CUTOFF, 24'hFFFFFF);
    write_reg(CFG_BINS_IN_USE, 24'd2047);
    send_bin_op(OP_RECORD, 24'd1024, '0);
    send_bin_op(OP_RECORD, 24'd1025, '0);
    send_bin_op(OP_READ, '0, 10'd1023);
    wait_histogram_idle();
    write_reg(CFG_BIN_WIDTH, 24'd0);
    send_bin_op(OP_RECORD, 24'd5, '0);
    wait_histogram_idle();
    write_reg(CFG_BIN_WIDTH, 24'hFFFFF);
    write_reg(CFG_TIME_CUTOFF, 24'd0);
    write_reg(CFG_BINS_IN_USE, 24'd0);
    send_bin_op(OP_RECORD, 24'd1, '0);
    send_bin_op(OP_READ, '0, 10'd0);
  endtask

  // Phases of random traffic, each under its own register setting
  task automatic test_random_histogram();
    logic [WIDTH_BITS-1:0] w;
    logic [TIME_BITS-1:0] c;
    logic [BINS_BITS-1:0] b;
    longint unsigned span;
    int unsigned eff;
    int unsigned pick;
    logic [TIME_BITS-1:0] t;
    logic [READ_BITS-1:0] rb;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin w = 20'd1; c = 24'hFFFFFF; b = 11'd1024; end
        1: begin w = 20'hFFFFF; c = 24'hFFFFFF; b = 11'd16; end
        2: begin
          w = WIDTH_BITS'($urandom_range(16, 1));
          c = TIME_BITS'($urandom_range(4096, 1));
          b = 11'd1;
        end
        3: begin
          w = WIDTH_BITS'($urandom_range(2000, 1));
          c = TIME_BITS'($urandom_range(24'hFFFFFF, 0));
          b = 11'd4;
        end
        4: begin
          w = WIDTH_BITS'($urandom_range(20'hFFFFF, 1));
          c = TIME_BITS'($urandom_range(24'hFFFFFF, 0));
          b = BINS_BITS'($urandom_range(2047, 0));
        end
        5: begin w = BIN_WIDTH_RESET; c = TIME_CUTOFF_RESET; b = BINS_IN_USE_RESET; end
        6: begin
          w = WIDTH_BITS'($urandom_range(256, 1));
          c = 24'hFFFFFF;
          b = BINS_BITS'($urandom_range(2047, 1025));
        end
        default: begin
          w = WIDTH_BITS'($urandom_range(20'hFFFFF, 1));
          c = TIME_BITS'($urandom_range(24'hFFFFFF, 0));
          b = BINS_BITS'($urandom_range(1024, 1));
        end
      endcase
      wait_histogram_idle();
      write_reg(CFG_BINS_IN_USE, CFG_DATA_BITS'(b));
      write_reg(CFG_TIME_CUTOFF, CFG_DATA_BITS'(c));
      write_reg(CFG_BIN_WIDTH, CFG_DATA_BITS'(w));

      // Range of times that land in a counted bin
      eff = bins_effective();
      span = longint'(eff) * width_q;
      if (span > cutoff_q) span = cutoff_q;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
          if (span != 0 && $urandom_range(4, 0) != 0)
            t = TIME_BITS'($urandom_range(int'(span), 1));
          else
            t = TIME_BITS'($urandom_range(24'hFFFFFF, 0));
          send_bin_op(OP_RECORD, t, READ_BITS'($urandom_range(1023, 0)));
        end else if (pick < 93) begin
          if (eff != 0 && $urandom_range(4, 0) != 0)
            rb = READ_BITS'($urandom_range(eff - 1, 0));
          else
            rb = READ_BITS'($urandom_range(1023, 0));
          send_bin_op(OP_READ, TIME_BITS'($urandom_range(24'hFFFFFF, 0)), rb);
        end else if (pick < 99) begin
          send_bin_op(OP_UNUSED, TIME_BITS'($urandom_range(24'hFFFFFF, 0)),
                      READ_BITS'($urandom_range(1023, 0)));
        end else begin
          send_bin_op(OP_CLEAR, TIME_BITS'($urandom_range(24'hFFFFFF, 0)),
                      READ_BITS'($urandom_range(1023, 0)));
        end
      end
    end
  endtask

  // Receiver: stretches of no stall, light stall and heavy stall
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span  <= $urandom_range(200, 20);
      stall_style <= $urandom_range(2, 0);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(3, 0) == 0);
      default: rsp_stall <= ($urandom_range(7, 0) < 5);
    endcase
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    bin_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_bin_results.size() == 0) begin
        report_mismatch("unexpected result, bin_index", 32'(bin_index), '0);
      end else begin
        want = expected_bin_results.pop_front();
        if (bin_index !== want.index)
          report_mismatch("bin_index", 32'(bin_index), 32'(want.index));
        if (bin_count !== want.count)
          report_mismatch("bin_count", bin_count, want.count);
        if (accepted !== want.ok)
          report_mismatch("accepted", 32'(accepted), 32'(want.ok));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    reset_histogram_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_binning();
    test_register_extremes();
    test_random_histogram();
    wait_histogram_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
